FILE: design/stl_pkg.sv
// Package for the streaming string-to-integer converter.
// Holds widths, phase codes, character and radix constants and the
// character classification functions. No dependencies.
package stl_pkg;

    localparam int CHAR_W        = 8;
    localparam int BASE_W        = 6;
    localparam int VALUE_W       = 64;
    localparam int OFFSET_W      = 13;
    localparam int PHASE_W       = 3;
    localparam int PROD_W        = VALUE_W + BASE_W + 1;
    localparam int MAX_CHARS_DEF = 4096;

    localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HEXPFX = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd63;
    localparam logic [BASE_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = BASE_W'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = BASE_W'(c - CH_UP_A) + DIGIT_TEN;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = BASE_W'(c - CH_LO_A) + DIGIT_TEN;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: design/string_to_long_parser.sv
// Streaming string-to-integer converter, top level: handshakes, radix
// register and input word register. Uses stl_pkg and stl_conv_core.
//
// One character word is taken per clock and one result word is given for each, after
// it passes the input register and then the result register; the sustained rate
// is one word per cycle while the output side keeps taking. The cycle is set by the
// per-character step: a 64 by 6 bit multiply of the accumulator by the radix, the digit
// add and the saturation compare. The radix register is sampled when the first
// character after whitespace and sign is processed; write it only while idle.
module string_to_long_parser #(
    parameter int MAX_CHARS = stl_pkg::MAX_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [stl_pkg::BASE_W-1:0]   i_number_base,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [stl_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                         i_start_string,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [stl_pkg::VALUE_W-1:0]  o_value,
    output logic                         o_range_error,
    output logic                         o_finished,
    output logic [stl_pkg::OFFSET_W-1:0] o_end_offset,
    output logic                         o_any_digits
);

    logic [stl_pkg::BASE_W-1:0] r_number_base;
    logic                       r_in_valid;
    logic [stl_pkg::CHAR_W-1:0] r_char_code;
    logic                       r_start_string;
    logic                       r_out_valid;
    logic                       fire;
    logic                       in_take;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= stl_pkg::BASE_AUTO;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_number_base <= i_number_base;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the accepted word until the core takes it
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char_code    <= i_char_code;
            r_start_string <= i_start_string;
        end
    end

    stl_conv_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_char_code    (r_char_code),
        .i_start_string (r_start_string),
        .i_number_base  (r_number_base),
        .o_value        (o_value),
        .o_range_error  (o_range_error),
        .o_finished     (o_finished),
        .o_end_offset   (o_end_offset),
        .o_any_digits   (o_any_digits)
    );

endmodule

FILE: design/stl_acc_unit.sv
// Multiply-add of the accumulator by the radix with saturation check.
// Uses stl_pkg for widths and limits.
module stl_acc_unit (
    input  logic [stl_pkg::VALUE_W-1:0] i_acc,
    input  logic [stl_pkg::BASE_W-1:0]  i_base,
    input  logic [stl_pkg::BASE_W-1:0]  i_digit,
    input  logic                        i_negative,
    output logic [stl_pkg::VALUE_W-1:0] o_sum,
    output logic                        o_over
);

    logic [stl_pkg::PROD_W-1:0] prod;
    logic [stl_pkg::PROD_W-1:0] sum;
    logic [stl_pkg::PROD_W-1:0] lim;

    assign prod  = stl_pkg::PROD_W'(i_acc) * stl_pkg::PROD_W'(i_base);
    assign sum   = prod + stl_pkg::PROD_W'(i_digit);
    assign lim   = i_negative ? stl_pkg::PROD_W'(stl_pkg::VALUE_MIN)
                              : stl_pkg::PROD_W'(stl_pkg::VALUE_MAX);
    assign o_over = sum > lim;
    assign o_sum  = sum[stl_pkg::VALUE_W-1:0];

endmodule

FILE: design/stl_conv_core.sv
// Conversion state, per-character next-state logic and result register.
// Uses stl_pkg and stl_acc_unit.
module stl_conv_core #(
    parameter int MAX_CHARS = stl_pkg::MAX_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [stl_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                         i_start_string,
    input  logic [stl_pkg::BASE_W-1:0]   i_number_base,
    output logic [stl_pkg::VALUE_W-1:0]  o_value,
    output logic                         o_range_error,
    output logic                         o_finished,
    output logic [stl_pkg::OFFSET_W-1:0] o_end_offset,
    output logic                         o_any_digits
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_CHARS);

    logic [stl_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                        r_negative, n_negative;
    logic [stl_pkg::BASE_W-1:0]  r_active_base, n_active_base;
    logic [stl_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic                        r_over, n_over;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [POS_W-1:0]            r_end_pos, n_end_pos;

    logic [stl_pkg::PHASE_W-1:0] cur_phase;
    logic                        cur_negative;
    logic [stl_pkg::BASE_W-1:0]  cur_base;
    logic [stl_pkg::VALUE_W-1:0] cur_acc;
    logic                        cur_over;
    logic [POS_W-1:0]            cur_pos;
    logic [POS_W-1:0]            cur_end_pos;
    logic [POS_W-1:0]            pos_inc;

    logic [stl_pkg::BASE_W-1:0]  digit;
    logic [stl_pkg::BASE_W-1:0]  take_base;
    logic [stl_pkg::BASE_W-1:0]  cfg_base;
    logic                        take;
    logic                        first;
    logic [stl_pkg::VALUE_W-1:0] sum;
    logic                        sum_over;
    logic [stl_pkg::VALUE_W-1:0] n_value;
    logic [POS_W+stl_pkg::OFFSET_W-1:0] end_ext;

    logic [stl_pkg::VALUE_W-1:0] r_value;
    logic                        r_range_error;
    logic                        r_finished;
    logic [stl_pkg::OFFSET_W-1:0] r_end_offset;
    logic                        r_any_digits;

    assign cur_phase    = i_start_string ? stl_pkg::PH_SPACE : r_phase;
    assign cur_negative = i_start_string ? 1'b0 : r_negative;
    assign cur_base     = i_start_string ? stl_pkg::BASE_AUTO : r_active_base;
    assign cur_acc      = i_start_string ? '0 : r_acc;
    assign cur_over     = i_start_string ? 1'b0 : r_over;
    assign cur_pos      = i_start_string ? '0 : r_pos;
    assign cur_end_pos  = i_start_string ? '0 : r_end_pos;
    assign pos_inc      = cur_pos + POS_W'(1);

    assign digit    = stl_pkg::digit_value(i_char_code);
    assign cfg_base = i_number_base;

    stl_acc_unit u_acc (
        .i_acc      (cur_acc),
        .i_base     (take_base),
        .i_digit    (digit),
        .i_negative (n_negative),
        .o_sum      (sum),
        .o_over     (sum_over)
    );

    always_comb begin
        n_phase       = cur_phase;
        n_negative    = cur_negative;
        n_active_base = cur_base;
        n_acc         = cur_acc;
        n_over        = cur_over;
        n_pos         = cur_pos;
        n_end_pos     = cur_end_pos;
        take          = 1'b0;
        first         = 1'b0;
        take_base     = cur_base;

        if (cur_phase != stl_pkg::PH_DONE) begin
            if (cur_pos >= MAX_POS) begin
                n_phase = stl_pkg::PH_DONE;
            end else begin
                n_pos = pos_inc;
                case (cur_phase)
                    stl_pkg::PH_SPACE: begin
                        if (stl_pkg::is_space(i_char_code)) begin
                            n_phase = cur_phase;
                        end else if (i_char_code == stl_pkg::CH_MINUS) begin
                            n_negative = 1'b1;
                            n_phase    = stl_pkg::PH_SIGNED;
                        end else if (i_char_code == stl_pkg::CH_PLUS) begin
                            n_phase = stl_pkg::PH_SIGNED;
                        end else begin
                            first = 1'b1;
                        end
                    end
                    stl_pkg::PH_SIGNED: begin
                        first = 1'b1;
                    end
                    stl_pkg::PH_ZERO: begin
                        if (i_char_code == stl_pkg::CH_LO_X ||
                            i_char_code == stl_pkg::CH_UP_X) begin
                            n_active_base = stl_pkg::BASE_HEX;
                            n_phase       = stl_pkg::PH_HEXPFX;
                        end else begin
                            take_base = (cur_base == stl_pkg::BASE_AUTO) ?
                                        stl_pkg::BASE_OCT : stl_pkg::BASE_HEX;
                            take      = 1'b1;
                        end
                    end
                    stl_pkg::PH_HEXPFX: begin
                        take_base = stl_pkg::BASE_HEX;
                        take      = 1'b1;
                    end
                    default: begin
                        take = 1'b1;
                    end
                endcase

                if (first) begin
                    if (i_char_code == stl_pkg::CH_ZERO &&
                        (cfg_base == stl_pkg::BASE_AUTO || cfg_base == stl_pkg::BASE_HEX)) begin
                        n_active_base = cfg_base;
                        n_acc         = '0;
                        n_end_pos     = pos_inc;
                        n_phase       = stl_pkg::PH_ZERO;
                    end else begin
                        take_base = (cfg_base == stl_pkg::BASE_AUTO) ?
                                    stl_pkg::BASE_DEC : cfg_base;
                        take      = 1'b1;
                    end
                end

                if (take) begin
                    n_active_base = take_base;
                    if (take_base < stl_pkg::BASE_MIN || take_base > stl_pkg::BASE_MAX ||
                        digit >= take_base) begin
                        n_phase = stl_pkg::PH_DONE;
                    end else begin
                        n_phase   = stl_pkg::PH_DIGITS;
                        n_end_pos = pos_inc;
                        if (!cur_over) begin
                            if (sum_over) begin
                                n_over = 1'b1;
                            end else begin
                                n_acc = sum;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (n_over) begin
            n_value = n_negative ? stl_pkg::VALUE_MIN : stl_pkg::VALUE_MAX;
        end else begin
            n_value = n_negative ? (~n_acc + stl_pkg::VALUE_W'(1)) : n_acc;
        end
    end

    assign end_ext = {{stl_pkg::OFFSET_W{1'b0}}, n_end_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= stl_pkg::PH_SPACE;
            r_negative    <= 1'b0;
            r_active_base <= stl_pkg::BASE_AUTO;
            r_acc         <= '0;
            r_over        <= 1'b0;
            r_pos         <= '0;
            r_end_pos     <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_negative    <= n_negative;
            r_active_base <= n_active_base;
            r_acc         <= n_acc;
            r_over        <= n_over;
            r_pos         <= n_pos;
            r_end_pos     <= n_end_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_value       <= n_value;
            r_range_error <= n_over;
            r_finished    <= (n_phase == stl_pkg::PH_DONE);
            r_end_offset  <= end_ext[stl_pkg::OFFSET_W-1:0];
            r_any_digits  <= (n_end_pos != '0);
        end
    end

    assign o_value       = r_value;
    assign o_range_error = r_range_error;
    assign o_finished    = r_finished;
    assign o_end_offset  = r_end_offset;
    assign o_any_digits  = r_any_digits;

endmodule

FILE: dv/tb.sv
// Testbench for string_to_long_parser: a short stimulus table, one saturating string,
// then random strings per radix setting, checked word by word against a predictor
// here or a table row's own expected word. Depends on stl_pkg and the design only.
module tb;

    localparam int SAT_LEN    = 40;
    localparam int ITEM_GOAL  = 600;
    localparam int QUIET_FROM = 520;

    typedef struct packed {
        logic [stl_pkg::VALUE_W-1:0]  value;
        logic                         range_error;
        logic                         finished;
        logic [stl_pkg::OFFSET_W-1:0] end_offset;
        logic                         any_digits;
    } t_result;

    typedef struct packed {
        logic [stl_pkg::BASE_W-1:0] radix;
        logic [stl_pkg::CHAR_W-1:0] ch;
        logic                       start;
        logic                       typed;
        t_result                    want;
    } t_row;

    localparam t_result NO_WANT = '0;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [stl_pkg::BASE_W-1:0]   i_number_base;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [stl_pkg::CHAR_W-1:0]   i_char_code;
    logic                         i_start_string;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [stl_pkg::VALUE_W-1:0]  o_value;
    logic                         o_range_error;
    logic                         o_finished;
    logic [stl_pkg::OFFSET_W-1:0] o_end_offset;
    logic                         o_any_digits;

    string_to_long_parser #(.MAX_CHARS(stl_pkg::MAX_CHARS_DEF)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_number_base  (i_number_base),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_start_string (i_start_string),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_range_error  (o_range_error),
        .o_finished     (o_finished),
        .o_end_offset   (o_end_offset),
        .o_any_digits   (o_any_digits)
    );

    always #6 i_clk = ~i_clk;

    // parser state as predicted
    logic [stl_pkg::PHASE_W-1:0] p_phase = stl_pkg::PH_SPACE;
    logic                        p_neg = 1'b0;
    logic [stl_pkg::BASE_W-1:0]  p_base = '0;
    logic [stl_pkg::VALUE_W-1:0] p_acc = '0;
    logic                        p_ovf = 1'b0;
    int unsigned                 p_pos = 0;
    int unsigned                 p_endp = 0;
    logic [stl_pkg::BASE_W-1:0]  radix_reg = stl_pkg::BASE_AUTO;

    t_result     expq[$];
    t_result     want;
    bit          new_str;
    int          gap_odds = 0;
    int          stall_odds = 0;
    int          stall_left = 0;
    int          items_sent = 0;
    int          strings = 0;
    int          cfg_writes = 0;
    int          sat_words = 0;
    int          errors = 0;
    t_row        script [0:24];

    function automatic int unsigned char_digit(input logic [stl_pkg::CHAR_W-1:0] c);
        if (c >= stl_pkg::CH_ZERO && c <= stl_pkg::CH_NINE) return c - stl_pkg::CH_ZERO;
        if (c >= stl_pkg::CH_UP_A && c <= stl_pkg::CH_UP_Z) return c - stl_pkg::CH_UP_A + 10;
        if (c >= stl_pkg::CH_LO_A && c <= stl_pkg::CH_LO_Z) return c - stl_pkg::CH_LO_A + 10;
        return 99;
    endfunction

    function automatic logic blank_char(input logic [stl_pkg::CHAR_W-1:0] c);
        return (c == stl_pkg::CH_SPACE) || (c >= stl_pkg::CH_TAB && c <= stl_pkg::CH_CR);
    endfunction

    function automatic logic [stl_pkg::CHAR_W-1:0] numeral(input int d, input bit upper);
        if (d < 10) return stl_pkg::CH_ZERO + stl_pkg::CHAR_W'(d);
        return (upper ? stl_pkg::CH_UP_A : stl_pkg::CH_LO_A) + stl_pkg::CHAR_W'(d - 10);
    endfunction

    task automatic take_digit(input logic [stl_pkg::CHAR_W-1:0] c);
        int unsigned                 d;
        logic [stl_pkg::VALUE_W-1:0] lim;
        d = char_digit(c);
        if (p_base < stl_pkg::BASE_MIN || p_base > stl_pkg::BASE_MAX || d >= p_base) begin
            p_phase = stl_pkg::PH_DONE;
            return;
        end
        p_phase = stl_pkg::PH_DIGITS;
        if (!p_ovf) begin
            lim = p_neg ? stl_pkg::VALUE_MIN : stl_pkg::VALUE_MAX;
            if (p_acc > (lim - stl_pkg::VALUE_W'(d)) / stl_pkg::VALUE_W'(p_base))
                p_ovf = 1'b1;
            else
                p_acc = p_acc * stl_pkg::VALUE_W'(p_base) + stl_pkg::VALUE_W'(d);
        end
        p_endp = p_pos + 1;
    endtask

    task automatic first_char(input logic [stl_pkg::CHAR_W-1:0] c);
        if (c == stl_pkg::CH_ZERO &&
            (radix_reg == stl_pkg::BASE_AUTO || radix_reg == stl_pkg::BASE_HEX)) begin
            p_base  = radix_reg;
            p_acc   = '0;
            p_endp  = p_pos + 1;
            p_phase = stl_pkg::PH_ZERO;
        end else begin
            p_base = (radix_reg == stl_pkg::BASE_AUTO) ? stl_pkg::BASE_DEC : radix_reg;
            take_digit(c);
        end
    endtask

    task automatic convert_char(input logic [stl_pkg::CHAR_W-1:0] c, input bit s,
                                output t_result r);
        if (s) begin
            p_phase = stl_pkg::PH_SPACE;
            p_neg   = 1'b0;
            p_base  = '0;
            p_acc   = '0;
            p_ovf   = 1'b0;
            p_pos   = 0;
            p_endp  = 0;
        end
        if (p_phase != stl_pkg::PH_DONE) begin
            if (p_pos >= stl_pkg::MAX_CHARS_DEF) begin
                p_phase = stl_pkg::PH_DONE;
            end else begin
                case (p_phase)
                    stl_pkg::PH_SPACE: begin
                        if (blank_char(c)) begin
                        end else if (c == stl_pkg::CH_MINUS) begin
                            p_neg   = 1'b1;
                            p_phase = stl_pkg::PH_SIGNED;
                        end else if (c == stl_pkg::CH_PLUS) begin
                            p_phase = stl_pkg::PH_SIGNED;
                        end else begin
                            first_char(c);
                        end
                    end
                    stl_pkg::PH_SIGNED: first_char(c);
                    stl_pkg::PH_ZERO: begin
                        if (c == stl_pkg::CH_LO_X || c == stl_pkg::CH_UP_X) begin
                            p_base  = stl_pkg::BASE_HEX;
                            p_phase = stl_pkg::PH_HEXPFX;
                        end else begin
                            p_base = (p_base == stl_pkg::BASE_AUTO) ?
                                     stl_pkg::BASE_OCT : stl_pkg::BASE_HEX;
                            take_digit(c);
                        end
                    end
                    stl_pkg::PH_HEXPFX: begin
                        p_base = stl_pkg::BASE_HEX;
                        take_digit(c);
                    end
                    default: take_digit(c);
                endcase
                if (p_pos < 32'h7FFF_FFFF) p_pos++;
            end
        end
        if (p_ovf) r.value = p_neg ? stl_pkg::VALUE_MIN : stl_pkg::VALUE_MAX;
        else r.value = p_neg ? (stl_pkg::VALUE_W'(0) - p_acc) : p_acc;
        r.range_error = p_ovf;
        r.finished    = (p_phase == stl_pkg::PH_DONE);
        r.end_offset  = stl_pkg::OFFSET_W'(p_endp);
        r.any_digits  = (p_endp != 0);
    endtask

    task automatic push_char(input logic [stl_pkg::CHAR_W-1:0] c);
        int      gap;
        t_result r;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_code    <= c;
        i_start_string <= new_str;
        do @(posedge i_clk); while (!o_in_ready);
        convert_char(c, new_str, r);
        expq.push_back(r);
        if (new_str) strings++;
        items_sent++;
        new_str = 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expq.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [stl_pkg::BASE_W-1:0] b);
        i_cfg_valid   <= 1'b1;
        i_number_base <= b;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radix_reg = b;
        cfg_writes++;
    endtask

    task automatic emit_string();
        logic [stl_pkg::VALUE_W-1:0] mag;
        logic [stl_pkg::CHAR_W-1:0]  digs[$];
        logic [stl_pkg::BASE_W-1:0]  eb;
        int                          n;
        bit                          neg;
        bit                          upper;
        bit                          no_digits;
        new_str = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                push_char(stl_pkg::CHAR_W'($urandom_range(0, 255)));
                new_str = ($urandom_range(0, 7) == 0);
            end
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            n = $urandom_range(8, 13);
            push_char(n == 8 ? stl_pkg::CH_SPACE : stl_pkg::CHAR_W'(n));
        end
        neg = 1'b0;
        case ($urandom_range(0, 2))
            1: push_char(stl_pkg::CH_PLUS);
            2: begin
                neg = 1'b1;
                push_char(stl_pkg::CH_MINUS);
            end
            default: ;
        endcase
        if ($urandom_range(0, 11) == 0)
            push_char($urandom_range(0, 1) ? stl_pkg::CH_PLUS : stl_pkg::CH_MINUS);
        upper = $urandom_range(0, 1);
        eb = radix_reg;
        if (radix_reg == stl_pkg::BASE_AUTO) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_char(stl_pkg::CH_ZERO);
                    push_char(upper ? stl_pkg::CH_UP_X : stl_pkg::CH_LO_X);
                    eb = stl_pkg::BASE_HEX;
                end
                1: begin
                    push_char(stl_pkg::CH_ZERO);
                    eb = stl_pkg::BASE_OCT;
                end
                default: eb = stl_pkg::BASE_DEC;
            endcase
        end else if (radix_reg == stl_pkg::BASE_HEX && $urandom_range(0, 1) == 1) begin
            push_char(stl_pkg::CH_ZERO);
            push_char(upper ? stl_pkg::CH_UP_X : stl_pkg::CH_LO_X);
        end else if (radix_reg < stl_pkg::BASE_MIN || radix_reg > stl_pkg::BASE_MAX) begin
            eb = stl_pkg::BASE_DEC;
        end
        no_digits = ($urandom_range(0, 11) == 0);
        case ($urandom_range(0, 3))
            0: mag = stl_pkg::VALUE_W'($urandom_range(0, 999));
            1: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: mag = (neg ? stl_pkg::VALUE_MIN : stl_pkg::VALUE_MAX) +
                     stl_pkg::VALUE_W'($urandom_range(0, 2)) - 64'd1;
            default: mag = {$urandom, $urandom};
        endcase
        while (mag != 0) begin
            digs.push_front(numeral(int'(mag % stl_pkg::VALUE_W'(eb)), upper));
            mag = mag / stl_pkg::VALUE_W'(eb);
        end
        if (digs.size() == 0) digs.push_back(stl_pkg::CH_ZERO);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 25))
                digs.push_back(numeral($urandom_range(0, eb - 1), upper));
        if (!no_digits)
            foreach (digs[i]) push_char(digs[i]);
        case ($urandom_range(0, 3))
            0: push_char(8'h00);
            1: push_char(stl_pkg::CH_SPACE);
            2: push_char(stl_pkg::CHAR_W'($urandom_range(0, 255)));
            default: ;
        endcase
        repeat ($urandom_range(0, 2)) push_char(stl_pkg::CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, exp_val);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expq.size() == 0) begin
                report_mismatch("word with nothing pending", o_value, '0);
            end else begin
                want = expq.pop_front();
                if (want.range_error) sat_words++;
                if (o_value !== want.value) report_mismatch("value", o_value, want.value);
                if (o_range_error !== want.range_error)
                    report_mismatch("range_error", o_range_error, want.range_error);
                if (o_finished !== want.finished)
                    report_mismatch("finished", o_finished, want.finished);
                if (o_end_offset !== want.end_offset)
                    report_mismatch("end_offset", o_end_offset, want.end_offset);
                if (o_any_digits !== want.any_digits)
                    report_mismatch("any_digits", o_any_digits, want.any_digits);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int target;
        script = '{
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_SPACE, 1'b1, 1'b1,
              '{64'd0, 1'b0, 1'b0, 13'd0, 1'b0}},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_TAB, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_MINUS, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_ZERO, 1'b0, 1'b1,
              '{64'd0, 1'b0, 1'b0, 13'd4, 1'b1}},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_LO_X, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, 8'h67, 1'b0, 1'b1,
              '{64'd0, 1'b0, 1'b1, 13'd4, 1'b1}},
            '{stl_pkg::BASE_AUTO, 8'hFF, 1'b0, 1'b1,
              '{64'd0, 1'b0, 1'b1, 13'd4, 1'b1}},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_ZERO, 1'b1, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_ZERO + 8'd8, 1'b0, 1'b1,
              '{64'd7, 1'b0, 1'b1, 13'd2, 1'b1}},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_PLUS, 1'b1, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, stl_pkg::CH_NINE, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_AUTO, 8'h00, 1'b0, 1'b1,
              '{64'd19, 1'b0, 1'b1, 13'd3, 1'b1}},
            '{stl_pkg::BASE_MAX, stl_pkg::CH_LO_Z, 1'b1, 1'b1,
              '{64'd35, 1'b0, 1'b0, 13'd1, 1'b1}},
            '{stl_pkg::BASE_MAX, stl_pkg::CH_UP_Z, 1'b0, 1'b1,
              '{64'd1295, 1'b0, 1'b0, 13'd2, 1'b1}},
            '{stl_pkg::BASE_MAX, stl_pkg::CH_CR, 1'b0, 1'b1,
              '{64'd1295, 1'b0, 1'b1, 13'd2, 1'b1}},
            '{stl_pkg::BASE_HEX, stl_pkg::CH_ZERO, 1'b1, 1'b0, NO_WANT},
            '{stl_pkg::BASE_HEX, stl_pkg::CH_UP_X, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_HEX, 8'h66, 1'b0, 1'b0, NO_WANT},
            '{stl_pkg::BASE_HEX, stl_pkg::CH_MINUS, 1'b0, 1'b0, NO_WANT},
            '{6'd1, stl_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1,
              '{64'd0, 1'b0, 1'b1, 13'd0, 1'b0}},
            '{6'd63, stl_pkg::CH_MINUS, 1'b1, 1'b0, NO_WANT},
            '{6'd63, stl_pkg::CH_ZERO, 1'b0, 1'b1,
              '{64'd0, 1'b0, 1'b1, 13'd0, 1'b0}},
            '{stl_pkg::BASE_MIN, stl_pkg::CH_ZERO + 8'd1, 1'b1, 1'b0, NO_WANT}
        };
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_number_base  <= '0;
        i_in_valid     <= 1'b0;
        i_char_code    <= '0;
        i_start_string <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 25; i++) begin
            if (script[i].radix != radix_reg) begin
                settle();
                write_radix(script[i].radix);
            end
            new_str = script[i].start;
            push_char(script[i].ch);
            if (script[i].typed) expq[$] = script[i].want;
        end

        // one negative string that saturates and keeps taking digits
        settle();
        write_radix(stl_pkg::BASE_DEC);
        gap_odds   = 4;
        stall_odds = 6;
        new_str = 1'b1;
        push_char(stl_pkg::CH_MINUS);
        push_char(stl_pkg::CH_NINE);
        repeat (SAT_LEN) push_char(stl_pkg::CH_ZERO + stl_pkg::CHAR_W'($urandom_range(0, 9)));

        while (items_sent < ITEM_GOAL) begin
            settle();
            case ($urandom_range(0, 9))
                0: write_radix(stl_pkg::BASE_AUTO);
                1: write_radix(stl_pkg::BASE_MIN);
                2: write_radix(stl_pkg::BASE_MAX);
                3: write_radix(stl_pkg::BASE_HEX);
                4: write_radix(stl_pkg::BASE_OCT);
                5: write_radix(stl_pkg::BASE_DEC);
                6: write_radix($urandom_range(0, 1) ? 6'd1 : 6'd63);
                default: write_radix(stl_pkg::BASE_W'($urandom_range(0, 63)));
            endcase
            if (items_sent >= QUIET_FROM) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
            end
            target = items_sent + $urandom_range(30, 60);
            while (items_sent < target) emit_string();
        end

        settle();
        repeat (6) @(posedge i_clk);
        $display("Sent %0d characters in %0d strings over %0d radix writes: signs, prefixes,",
                 items_sent, strings, cfg_writes);
        $display("terminators and stalls; %0d saturated words seen, %0d mismatches.",
                 sat_words, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
